@@ src/hcid_pkg.sv @@
// Package for the HCI H4 UART receive deframer.
// Holds the item and result types, the parse phase codes and protocol constants.
// No dependencies; every other file of the block but hcid_if imports it.
package hcid_pkg;

  // H4 packet type bytes and event codes that carry command credits.
  localparam logic [7:0] TYPE_EVENT       = 8'h04;
  localparam logic [7:0] TYPE_ACL         = 8'h02;
  localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
  localparam logic [7:0] EVT_CMD_STATUS   = 8'h0F;

  // Reset value of the ACL length limit.
  localparam logic [15:0] MAX_ACL_LEN_RST = 16'd1021;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ACL_LEN = 3'd0;

  // Role of a reported byte.
  localparam logic [3:0] ROLE_TYPE      = 4'd0;
  localparam logic [3:0] ROLE_EVT_CODE  = 4'd1;
  localparam logic [3:0] ROLE_EVT_LEN   = 4'd2;
  localparam logic [3:0] ROLE_EVT_PARAM = 4'd3;
  localparam logic [3:0] ROLE_HANDLE_LO = 4'd4;
  localparam logic [3:0] ROLE_HANDLE_HI = 4'd5;
  localparam logic [3:0] ROLE_LEN_LO    = 4'd6;
  localparam logic [3:0] ROLE_LEN_HI    = 4'd7;
  localparam logic [3:0] ROLE_ACL_DATA  = 4'd8;
  localparam logic [3:0] ROLE_DROPPED   = 4'd9;
  localparam logic [3:0] ROLE_SEND      = 4'd10;

  // Packet kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_ACL   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_TYPE = 2'd1;
  localparam logic [1:0] ERR_ACL_LEN  = 2'd2;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_TYPE      = 9'b000000001,
    PH_EVT_CODE  = 9'b000000010,
    PH_EVT_LEN   = 9'b000000100,
    PH_EVT_PARAM = 9'b000001000,
    PH_H_LO      = 9'b000010000,
    PH_H_HI      = 9'b000100000,
    PH_L_LO      = 9'b001000000,
    PH_L_HI      = 9'b010000000,
    PH_ACL_DATA  = 9'b100000000
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  packet_kind;
    logic [7:0]  pkt_event;
    logic [15:0] acl_handle;
    logic [15:0] payload_length;
    logic        last;
    logic [1:0]  error;
    logic [7:0]  credits;
    logic        send_granted;
  } result_t;

  // Handoff from the input register to the parser.
  typedef struct packed {
    logic  vld;
    item_t item;
  } stage_t;

endpackage

@@ src/hcid_if.sv @@
// Valid/ready channel interfaces for the HCI H4 receive deframer.
// Depends on nothing; the field widths follow the block's item and result layout.
interface hcid_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface hcid_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_role;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [1:0]  packet_kind;
  logic [7:0]  pkt_event;
  logic [15:0] acl_handle;
  logic [15:0] payload_length;
  logic        last;
  logic [1:0]  error;
  logic [7:0]  credits;
  logic        send_granted;

  modport source (output valid, byte_role, data_byte, byte_index, packet_kind, pkt_event,
                  acl_handle, payload_length, last, error, credits, send_granted,
                  input ready);
  modport sink   (input valid, byte_role, data_byte, byte_index, packet_kind, pkt_event,
                  acl_handle, payload_length, last, error, credits, send_granted,
                  output ready);
endinterface

@@ src/hcid_cfg_regs.sv @@
// APB-style configuration register file of the HCI H4 receive deframer.
// Holds the ACL length limit; depends on hcid_pkg.
module hcid_cfg_regs
  import hcid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [15:0]           max_acl_len
);

  logic [15:0] max_len_r;
  logic        sel_len;
  logic        wr_en;

  // Only word-aligned register zero exists; low address bits are ignored.
  assign sel_len = (paddr[CFG_ADDR_W-1:2] == REG_MAX_ACL_LEN[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register write in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_ACL_LEN_RST;
    end else if (wr_en && sel_len) begin
      max_len_r <= pwdata[15:0];
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    if (sel_len) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, max_len_r};
    end
  end

  assign max_acl_len = max_len_r;

endmodule

@@ src/hcid_in_stage.sv @@
// Input register of the HCI H4 receive deframer.
// Captures one transaction per cycle while the downstream stage advances; uses hcid_pkg.
module hcid_in_stage
  import hcid_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  hcid_in_if.sink in_ch,
  input  logic    advance,
  output stage_t  stage
);

  logic  vld_r;
  item_t item_r;
  logic  take;

  // Accept whenever the register is empty or drains this cycle.
  assign in_ch.ready = !vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.cmd     <= in_ch.cmd;
      item_r.rx_byte <= in_ch.rx_byte;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

@@ src/hcid_parser.sv @@
// H4 packet parser and command credit counter of the HCI receive deframer.
// Holds the parse state and computes one result per step; uses hcid_pkg.
module hcid_parser
  import hcid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  item_t       item,
  input  logic [15:0] max_acl_len,
  output result_t     res
);

  phase_t      phase_r,   phase_nxt;
  logic [1:0]  kind_r,    kind_nxt;
  logic [7:0]  event_r,   event_nxt;
  logic [15:0] handle_r,  handle_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] seen_r,    seen_nxt;
  logic [7:0]  credit_r,  credit_nxt;
  logic [7:0]  pend_r,    pend_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic        fin;
  logic [7:0]  b;

  assign b = item.rx_byte;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    event_nxt    = event_r;
    handle_nxt   = handle_r;
    len_nxt      = len_r;
    seen_nxt     = seen_r;
    credit_nxt   = credit_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    fin          = 1'b0;
    res          = '0;

    if (item.cmd) begin
      // Send request: take a credit if one is left.
      if (credit_r != 8'd0) begin
        credit_nxt       = credit_r - 8'd1;
        res.send_granted = 1'b1;
      end
      res.byte_role = ROLE_SEND;
      res.credits   = credit_nxt;
    end else begin
      res.data_byte = b;
      case (phase_r)
        PH_TYPE: begin
          event_nxt    = '0;
          handle_nxt   = '0;
          len_nxt      = '0;
          seen_nxt     = '0;
          pend_vld_nxt = 1'b0;
          if (b == TYPE_EVENT) begin
            kind_nxt      = KIND_EVENT;
            phase_nxt     = PH_EVT_CODE;
            res.byte_role = ROLE_TYPE;
          end else if (b == TYPE_ACL) begin
            kind_nxt      = KIND_ACL;
            phase_nxt     = PH_H_LO;
            res.byte_role = ROLE_TYPE;
          end else begin
            kind_nxt      = KIND_NONE;
            res.byte_role = ROLE_DROPPED;
            res.error     = ERR_BAD_TYPE;
          end
        end
        PH_EVT_CODE: begin
          event_nxt     = b;
          res.byte_role = ROLE_EVT_CODE;
          phase_nxt     = PH_EVT_LEN;
        end
        PH_EVT_LEN: begin
          len_nxt       = {8'd0, b};
          res.byte_role = ROLE_EVT_LEN;
          if (b == 8'd0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_EVT_PARAM;
          end
        end
        PH_EVT_PARAM: begin
          res.byte_role  = ROLE_EVT_PARAM;
          res.byte_index = seen_r;
          // Credit field: parameter 0 of Command Complete, 1 of Command Status.
          if ((event_r == EVT_CMD_COMPLETE && seen_r == 16'd0) ||
              (event_r == EVT_CMD_STATUS && seen_r == 16'd1)) begin
            pend_nxt     = b;
            pend_vld_nxt = 1'b1;
          end
          seen_nxt = seen_r + 16'd1;
          fin      = (seen_nxt >= len_r);
        end
        PH_H_LO: begin
          handle_nxt    = {8'd0, b};
          res.byte_role = ROLE_HANDLE_LO;
          phase_nxt     = PH_H_HI;
        end
        PH_H_HI: begin
          handle_nxt    = {b, handle_r[7:0]};
          res.byte_role = ROLE_HANDLE_HI;
          phase_nxt     = PH_L_LO;
        end
        PH_L_LO: begin
          len_nxt       = {8'd0, b};
          res.byte_role = ROLE_LEN_LO;
          phase_nxt     = PH_L_HI;
        end
        PH_L_HI: begin
          len_nxt       = {b, len_r[7:0]};
          res.byte_role = ROLE_LEN_HI;
          if (len_nxt > max_acl_len) begin
            // Oversized packet: flag it and hunt for the next type byte.
            res.error    = ERR_ACL_LEN;
            pend_vld_nxt = 1'b0;
            phase_nxt    = PH_TYPE;
          end else if (len_nxt == 16'd0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_ACL_DATA;
          end
        end
        PH_ACL_DATA: begin
          res.byte_role  = ROLE_ACL_DATA;
          res.byte_index = seen_r;
          seen_nxt       = seen_r + 16'd1;
          fin            = (seen_nxt >= len_r);
        end
        default: begin
          phase_nxt     = PH_TYPE;
          res.byte_role = ROLE_DROPPED;
        end
      endcase

      // End of packet: apply a pending credit reload.
      if (fin) begin
        if (pend_vld_nxt) begin
          credit_nxt = pend_nxt;
        end
        pend_vld_nxt = 1'b0;
        phase_nxt    = PH_TYPE;
      end

      res.packet_kind    = kind_nxt;
      res.pkt_event      = event_nxt;
      res.acl_handle     = handle_nxt;
      res.payload_length = len_nxt;
      res.last           = fin;
      res.credits        = credit_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TYPE;
      kind_r     <= KIND_NONE;
      event_r    <= '0;
      handle_r   <= '0;
      len_r      <= '0;
      seen_r     <= '0;
      credit_r   <= 8'd1;
      pend_r     <= '0;
      pend_vld_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      event_r    <= event_nxt;
      handle_r   <= handle_nxt;
      len_r      <= len_nxt;
      seen_r     <= seen_nxt;
      credit_r   <= credit_nxt;
      pend_r     <= pend_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // A pending reload never survives into the wait for a new packet.
  a_no_pend_at_type: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TYPE) |-> !pend_vld_r)
    else $error("pending credit valid while waiting for a type byte");

  // A refused send leaves the credit count at zero.
  a_refused_stays_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.cmd && credit_r == 8'd0) |=> (credit_r == 8'd0))
    else $error("credit count moved after a refused send");

  // Received bytes never change the credits except at the end of a packet.
  a_credit_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.cmd && !fin) |=> $stable(credit_r))
    else $error("credit count changed in the middle of a packet");

  // Parameter and payload indexes start from zero after a type byte.
  a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.cmd && phase_r == PH_TYPE) |=> (seen_r == 16'd0))
    else $error("byte counter not cleared by a type byte");

endmodule

@@ src/hcid_out_stage.sv @@
// Result register of the HCI H4 receive deframer.
// Holds one finished result until the sink takes it; uses hcid_pkg.
module hcid_out_stage
  import hcid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        advance,
  hcid_out_if.source  out_ch
);

  logic    vld_r;
  result_t res_r;

  // The register can take a new result when empty or being drained.
  assign advance = !vld_r || out_ch.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= load;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (load && advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.byte_role      = res_r.byte_role;
  assign out_ch.data_byte      = res_r.data_byte;
  assign out_ch.byte_index     = res_r.byte_index;
  assign out_ch.packet_kind    = res_r.packet_kind;
  assign out_ch.pkt_event      = res_r.pkt_event;
  assign out_ch.acl_handle     = res_r.acl_handle;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.last           = res_r.last;
  assign out_ch.error          = res_r.error;
  assign out_ch.credits        = res_r.credits;
  assign out_ch.send_granted   = res_r.send_granted;

endmodule

@@ src/hci_uart_receive_deframer.sv @@
// Receive deframer for the Bluetooth HCI H4 UART transport with command credit tracking.
// Each input transaction is one received UART byte or one host request to send a command,
// and each yields exactly one result transaction: the byte's role, index, packet kind,
// header fields, end-of-packet flag, error code and the credit count. The block takes one
// transaction per clock while the result sink keeps up; each passes the input register,
// the single pass of parse logic and the result register. Credits start at one, reload at
// the end of a Command Complete or Command Status event, and drop by one per granted send.
// Depends on hcid_pkg, hcid_if, hcid_cfg_regs, hcid_in_stage, hcid_parser, hcid_out_stage.
module hci_uart_receive_deframer
  import hcid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hcid_in_if.sink               in_ch,
  hcid_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [15:0] max_acl_len;
  logic        advance;
  logic        step;
  stage_t      stage;
  result_t     res;

  // Configuration registers.
  hcid_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .max_acl_len (max_acl_len)
  );

  // Input register.
  hcid_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // The parser steps when an item is held and the result register can take it.
  assign step = stage.vld && advance;

  hcid_parser u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (stage.item),
    .max_acl_len (max_acl_len),
    .res         (res)
  );

  // Result register.
  hcid_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (stage.vld),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

@@ dv/hcid_deframer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the HCI H4 receive deframer: watches the item, result and register ports.
// Keeps its own H4 parser and credit count and compares every result in order.
// Depends on hcid_pkg and the channel interfaces in hcid_if.
module hcid_deframer_checker
  import hcid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hcid_in_if                    in_ch,
  hcid_out_if                   out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    reports_due
);

  // Parser state and the register copy.
  phase_t      phase;
  logic [1:0]  kind;
  logic [7:0]  evt_code;
  logic [15:0] handle;
  logic [15:0] decl_len;
  logic [15:0] seen;
  logic [7:0]  credit_cnt;
  logic [7:0]  credit_next;
  logic        credit_next_ok;
  logic [15:0] acl_limit;

  // Byte reports that the block still owes, oldest first.
  result_t byte_reports_q[$];

  initial begin
    mismatches  = 0;
    reports_due = 0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // End of a packet: a pending credit reload takes effect here.
  task automatic close_packet();
    if (credit_next_ok) begin
      credit_cnt = credit_next;
    end
    credit_next_ok = 1'b0;
    phase          = PH_TYPE;
  endtask

  // Advance the parser by one transaction and build the report it yields.
  task automatic parse_h4_item(input item_t it, output result_t rep);
    logic [7:0]  b;
    logic [3:0]  role;
    logic [15:0] idx;
    logic        last;
    logic [1:0]  err;
    b    = it.rx_byte;
    rep  = '0;
    role = ROLE_TYPE;
    idx  = '0;
    last = 1'b0;
    err  = ERR_NONE;
    if (it.cmd) begin
      // A send request touches only the credit count.
      if (credit_cnt != 8'd0) begin
        credit_cnt       = credit_cnt - 8'd1;
        rep.send_granted = 1'b1;
      end
      rep.byte_role = ROLE_SEND;
      rep.credits   = credit_cnt;
    end else begin
      case (phase)
        PH_TYPE: begin
          evt_code       = '0;
          handle         = '0;
          decl_len       = '0;
          seen           = '0;
          credit_next_ok = 1'b0;
          if (b == TYPE_EVENT) begin
            kind  = KIND_EVENT;
            phase = PH_EVT_CODE;
          end else if (b == TYPE_ACL) begin
            kind  = KIND_ACL;
            phase = PH_H_LO;
          end else begin
            kind = KIND_NONE;
            role = ROLE_DROPPED;
            err  = ERR_BAD_TYPE;
          end
        end
        PH_EVT_CODE: begin
          evt_code = b;
          role     = ROLE_EVT_CODE;
          phase    = PH_EVT_LEN;
        end
        PH_EVT_LEN: begin
          decl_len = {8'h00, b};
          role     = ROLE_EVT_LEN;
          if (b == 8'd0) begin
            last = 1'b1;
            close_packet();
          end else begin
            phase = PH_EVT_PARAM;
          end
        end
        PH_EVT_PARAM: begin
          role = ROLE_EVT_PARAM;
          idx  = seen;
          // Command Complete carries credits in parameter 0, Command Status in 1.
          if ((evt_code == EVT_CMD_COMPLETE && seen == 16'd0) ||
              (evt_code == EVT_CMD_STATUS && seen == 16'd1)) begin
            credit_next    = b;
            credit_next_ok = 1'b1;
          end
          seen = seen + 16'd1;
          if (seen >= decl_len) begin
            last = 1'b1;
            close_packet();
          end
        end
        PH_H_LO: begin
          handle = {8'h00, b};
          role   = ROLE_HANDLE_LO;
          phase  = PH_H_HI;
        end
        PH_H_HI: begin
          handle[15:8] = b;
          role         = ROLE_HANDLE_HI;
          phase        = PH_L_LO;
        end
        PH_L_LO: begin
          decl_len = {8'h00, b};
          role     = ROLE_LEN_LO;
          phase    = PH_L_HI;
        end
        PH_L_HI: begin
          decl_len[15:8] = b;
          role           = ROLE_LEN_HI;
          if (decl_len > acl_limit) begin
            // Oversized packet: flagged and dropped, next byte is a type byte.
            err            = ERR_ACL_LEN;
            credit_next_ok = 1'b0;
            phase          = PH_TYPE;
          end else if (decl_len == 16'd0) begin
            last = 1'b1;
            close_packet();
          end else begin
            phase = PH_ACL_DATA;
          end
        end
        PH_ACL_DATA: begin
          role = ROLE_ACL_DATA;
          idx  = seen;
          seen = seen + 16'd1;
          if (seen >= decl_len) begin
            last = 1'b1;
            close_packet();
          end
        end
        default: begin
          phase = PH_TYPE;
          role  = ROLE_DROPPED;
        end
      endcase
      rep.byte_role      = role;
      rep.data_byte      = b;
      rep.byte_index     = idx;
      rep.packet_kind    = kind;
      rep.pkt_event      = evt_code;
      rep.acl_handle     = handle;
      rep.payload_length = decl_len;
      rep.last           = last;
      rep.error          = err;
      rep.credits        = credit_cnt;
    end
  endtask

  // Compare results first, then apply register writes, then predict new items.
  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    if (!rst_n) begin
      phase          = PH_TYPE;
      kind           = KIND_NONE;
      evt_code       = '0;
      handle         = '0;
      decl_len       = '0;
      seen           = '0;
      credit_cnt     = 8'd1;
      credit_next    = '0;
      credit_next_ok = 1'b0;
      acl_limit      = MAX_ACL_LEN_RST;
      byte_reports_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (byte_reports_q.size() == 0) begin
          report_mismatch("result transaction with no item outstanding");
        end else begin
          want = byte_reports_q.pop_front();
          check_field("byte_role", out_ch.byte_role, want.byte_role);
          check_field("data_byte", out_ch.data_byte, want.data_byte);
          check_field("byte_index", out_ch.byte_index, want.byte_index);
          check_field("packet_kind", out_ch.packet_kind, want.packet_kind);
          check_field("pkt_event", out_ch.pkt_event, want.pkt_event);
          check_field("acl_handle", out_ch.acl_handle, want.acl_handle);
          check_field("payload_length", out_ch.payload_length, want.payload_length);
          check_field("last", out_ch.last, want.last);
          check_field("error", out_ch.error, want.error);
          check_field("credits", out_ch.credits, want.credits);
          check_field("send_granted", out_ch.send_granted, want.send_granted);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_MAX_ACL_LEN) begin
        acl_limit = cfg_pwdata[15:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        it.cmd     = in_ch.cmd;
        it.rx_byte = in_ch.rx_byte;
        parse_h4_item(it, want);
        byte_reports_q.push_back(want);
      end
    end
    reports_due <= byte_reports_q.size();
  end

endmodule

@@ dv/tb_hci_uart_receive_deframer.sv @@
`timescale 1ns / 1ps
// Testbench top for the HCI H4 receive deframer: clock, reset, stimulus and verdict.
// Drives H4 packets, stray bytes and send requests; checking lives in hcid_deframer_checker.
// Depends on hcid_pkg, hcid_if, the block and the checker.
module tb_hci_uart_receive_deframer
  import hcid_pkg::*;
;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 180;
  localparam int SETTLE_CYCLES = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    mismatches;
  int                    reports_due;
  int                    cycle_count;
  int                    items_sent;
  int                    acl_limit;
  logic                  calm;

  hcid_in_if  in_ch();
  hcid_out_if out_ch();

  hci_uart_receive_deframer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  hcid_deframer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .mismatches (mismatches),
    .reports_due(reports_due)
  );

  // Opening sequence, {cmd, byte}: granted and refused sends, a bad type byte,
  // a Command Complete too short for credits, credit reloads from Command Complete
  // and Command Status, an oversized ACL packet and a zero-length ACL packet.
  logic [8:0] opening_seq[$] = '{
    {1'b1, 8'h00}, {1'b1, 8'h5A},
    {1'b0, 8'hFF},
    {1'b0, TYPE_EVENT}, {1'b0, EVT_CMD_COMPLETE}, {1'b0, 8'h00},
    {1'b0, TYPE_EVENT}, {1'b0, EVT_CMD_COMPLETE}, {1'b0, 8'h01}, {1'b0, 8'h05},
    {1'b0, TYPE_EVENT}, {1'b0, EVT_CMD_STATUS}, {1'b0, 8'h02}, {1'b0, 8'h00},
    {1'b0, 8'hFF},
    {1'b0, TYPE_ACL}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFE}, {1'b0, 8'h03},
    {1'b0, TYPE_ACL}, {1'b0, 8'h34}, {1'b0, 8'h12}, {1'b0, 8'h00}, {1'b0, 8'h00}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side backpressure; none while the calm stretch runs.
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 35);
  end

  // Hard stop if the run hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hci_uart_receive_deframer: mismatch");
      $finish;
    end
  end

  // Offer one transaction and hold it until the block takes it. Entered and left
  // at a falling edge; valid stays high for back-to-back transactions.
  task automatic send_item(input logic c, input logic [7:0] b);
    if (!calm && $urandom_range(99) < 35) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.cmd     = c;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // A received byte, sometimes preceded by a host send request.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 8) begin
      send_item(1'b1, 8'($urandom_range(255)));
    end
    send_item(1'b0, b);
  endtask

  // Event packet; credit events are common and credit values are mostly small.
  task automatic send_event();
    int         pick;
    logic [7:0] code;
    logic [7:0] len;
    pick = $urandom_range(99);
    if (pick < 30) begin
      code = EVT_CMD_COMPLETE;
    end else if (pick < 60) begin
      code = EVT_CMD_STATUS;
    end else begin
      code = 8'($urandom_range(255));
    end
    len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
    send_byte(TYPE_EVENT);
    send_byte(code);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      send_byte($urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255)));
    end
  endtask

  // ACL packet, either within the limit with a short payload or oversized.
  task automatic send_acl(input bit oversized);
    int          len;
    logic [15:0] len16;
    logic [15:0] hdl;
    if (oversized) begin
      len = $urandom_range(acl_limit + 1, 65535);
    end else if (acl_limit <= 64 && $urandom_range(9) == 0) begin
      len = acl_limit;
    end else begin
      len = $urandom_range(0, (acl_limit < 12) ? acl_limit : 12);
    end
    len16 = 16'(len);
    hdl   = 16'($urandom);
    send_byte(TYPE_ACL);
    send_byte(hdl[7:0]);
    send_byte(hdl[15:8]);
    send_byte(len16[7:0]);
    send_byte(len16[15:8]);
    if (!oversized) begin
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // A stray byte that is not a packet type.
  task automatic send_stray();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == TYPE_ACL || b == TYPE_EVENT);
    send_byte(b);
  endtask

  // Mostly well-formed packets, with oversized ACL, stray bytes and send bursts.
  task automatic run_traffic(input int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_event();
      end else if (pick < 80) begin
        send_acl(1'b0);
      end else if (pick < 88) begin
        send_acl(acl_limit < 65535);
      end else if (pick < 94) begin
        send_stray();
      end else begin
        repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom_range(255)));
      end
    end
  endtask

  // Let every outstanding result arrive, then wait out SETTLE_CYCLES.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic write_acl_limit(input int value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = REG_MAX_ACL_LEN;
    cfg_pwdata  = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    acl_limit   = value;
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n         = 1'b0;
    calm          = 1'b0;
    items_sent    = 0;
    acl_limit     = MAX_ACL_LEN_RST;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (opening_seq[i]) begin
      send_item(opening_seq[i][8], opening_seq[i][7:0]);
    end
    run_traffic(PHASE_ITEMS);
    drain();

    // Limit at zero: only empty ACL packets pass.
    write_acl_limit(0);
    run_traffic(PHASE_ITEMS);
    drain();

    // Largest limit, run without any idling on either side.
    write_acl_limit(65535);
    calm = 1'b1;
    run_traffic(PHASE_ITEMS);
    drain();
    calm = 1'b0;

    // Small random limit, so payloads at the limit occur.
    write_acl_limit($urandom_range(1, 40));
    run_traffic(PHASE_ITEMS);
    drain();

    // Any limit, then back to the reset value.
    write_acl_limit($urandom_range(65535));
    run_traffic(PHASE_ITEMS / 2);
    drain();
    write_acl_limit(MAX_ACL_LEN_RST);
    run_traffic(PHASE_ITEMS / 2);
    drain();

    if (mismatches == 0) begin
      $display("hci_uart_receive_deframer: match");
    end else begin
      $display("hci_uart_receive_deframer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/hcid_pkg.sv
src/hcid_if.sv
src/hcid_cfg_regs.sv
src/hcid_in_stage.sv
src/hcid_parser.sv
src/hcid_out_stage.sv
src/hci_uart_receive_deframer.sv
dv/hcid_deframer_checker.sv
dv/tb_hci_uart_receive_deframer.sv
